// ===== sv/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg: shared constants, types and functions of the purity scorer
// Sizes of the contingency table, counter widths and the divider status type.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int LABELS     = 16;
  localparam int COUNT_BITS = 16;

  localparam int LABEL_IN_W = 4;
  localparam int LBL_W      = (LABELS > 1) ? $clog2(LABELS) : 1;
  localparam int DEPTH      = LABELS * LABELS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SUM_W      = COUNT_BITS + LBL_W;
  localparam int OUT_W      = 16;
  localparam int FRAC_BITS  = 16;
  localparam int PUR_W      = FRAC_BITS + 1;
  localparam int FRAC_CNT_W = $clog2(FRAC_BITS);
  localparam int OUT_MAX    = 65535;

  typedef struct packed {
    logic             done;
    logic [PUR_W-1:0] quot;
  } div_stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    if (v == {COUNT_BITS{1'b1}}) begin
      r = v;
    end else begin
      r = v + COUNT_BITS'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/cps_ram.sv =====
// ----------------------------------------------------------------------------
// cps_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cps_div.sv =====
// ----------------------------------------------------------------------------
// cps_div: restoring divider for the purity fraction
// Produces floor(sum * 2^16 / total), one quotient bit per cycle, and
// saturates at 1.0 when the sum is not below the total.
// ----------------------------------------------------------------------------
module cps_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cps_pkg::SUM_W-1:0]      sum_i,
  input  logic [cps_pkg::COUNT_BITS-1:0] total_i,
  output cps_pkg::div_stat_t             stat_o
);

  typedef enum logic {DV_IDLE, DV_RUN} state_e;

  state_e                              state_q;
  logic                                done_q;
  logic [cps_pkg::PUR_W-1:0]           quot_q;
  logic [cps_pkg::COUNT_BITS-1:0]      rem_q;
  logic [cps_pkg::COUNT_BITS-1:0]      total_q;
  logic [cps_pkg::FRAC_BITS-1:0]       bits_q;
  logic [cps_pkg::FRAC_CNT_W-1:0]      cnt_q;

  logic [cps_pkg::COUNT_BITS:0]        rem2;
  logic [cps_pkg::COUNT_BITS:0]        rem_sub;
  logic                                take;
  logic [cps_pkg::FRAC_BITS-1:0]       bits_d;

  always_comb begin
    rem2    = {rem_q, 1'b0};
    rem_sub = rem2 - {1'b0, total_q};
    take    = (rem2 >= {1'b0, total_q});
    bits_d  = {bits_q[cps_pkg::FRAC_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (start_i) begin
        total_q <= total_i;
        bits_q  <= '0;
        cnt_q   <= '0;
        // A sum at or above the count means purity of at least one.
        if (sum_i >= cps_pkg::SUM_W'(total_i)) begin
          quot_q  <= {1'b1, {cps_pkg::FRAC_BITS{1'b0}}};
          done_q  <= 1'b1;
          state_q <= DV_IDLE;
        end else begin
          done_q  <= 1'b0;
          rem_q   <= cps_pkg::COUNT_BITS'(sum_i);
          state_q <= DV_RUN;
        end
      end else begin
        unique case (state_q)
          DV_IDLE: begin
          end
          DV_RUN: begin
            if (take) begin
              rem_q <= cps_pkg::COUNT_BITS'(rem_sub);
            end else begin
              rem_q <= cps_pkg::COUNT_BITS'(rem2);
            end
            bits_q <= bits_d;
            cnt_q  <= cnt_q + cps_pkg::FRAC_CNT_W'(1);
            if (cnt_q == cps_pkg::FRAC_CNT_W'(cps_pkg::FRAC_BITS - 1)) begin
              quot_q  <= {1'b0, bits_d};
              done_q  <= 1'b1;
              state_q <= DV_IDLE;
            end
          end
          default: state_q <= DV_IDLE;
        endcase
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule

// ===== sv/cluster_purity_score.sv =====
// ----------------------------------------------------------------------------
// cluster_purity_score: clustering purity over a stream of labelled items
// Contingency-table counting in a RAM, row-maximum walk and purity division.
// ----------------------------------------------------------------------------
// Each item increments one saturating cell of a LABELS x LABELS table (row
// by found label, column by reference label) held in a single RAM, with a
// read-modify-write that forwards the last written value, so items are taken
// one per cycle while the block accumulates. Labels at or above LABELS count
// as LABELS-1. The item marked last ends the data set: the block then walks
// the whole table through the RAM read port, one entry per cycle, keeping the
// maximum of each row, adding it to the sum and writing the entry back to
// zero. A 16-step divider then forms the purity, and the result is loaded
// into the output register. From the last item to the result the block
// passes through a flush state, the walk, a tail state, the divider start
// and the divider run, which is skipped when the purity saturates at one; a
// full output register holds the result back until it is free. Items are
// taken again while the result waits on the output. After reset the block
// zeroes every table entry before it takes items.
module cluster_purity_score (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cps_pkg::LABEL_IN_W-1:0] reference_label_i,
  input  logic [cps_pkg::LABEL_IN_W-1:0] found_label_i,
  input  logic                           last_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cps_pkg::OUT_W-1:0]      overlap_sum_o,
  output logic [cps_pkg::OUT_W-1:0]      item_total_o,
  output logic [cps_pkg::PUR_W-1:0]      purity_fraction_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_ACCUM, ST_FLUSH, ST_WALK, ST_TAIL, ST_DIV_START, ST_DIV_WAIT
  } state_e;

  function automatic logic [cps_pkg::LBL_W-1:0] clamp_label(
    input logic [cps_pkg::LABEL_IN_W-1:0] v
  );
    logic [cps_pkg::LBL_W-1:0] r;
    if (32'(v) >= 32'(cps_pkg::LABELS)) begin
      r = cps_pkg::LBL_W'(cps_pkg::LABELS - 1);
    end else begin
      r = cps_pkg::LBL_W'(v);
    end
    return r;
  endfunction

  function automatic logic [cps_pkg::OUT_W-1:0] sat_out(
    input logic [cps_pkg::SUM_W-1:0] v
  );
    logic [cps_pkg::OUT_W-1:0] r;
    if (v > cps_pkg::SUM_W'(cps_pkg::OUT_MAX)) begin
      r = {cps_pkg::OUT_W{1'b1}};
    end else begin
      r = cps_pkg::OUT_W'(v);
    end
    return r;
  endfunction

  state_e                           state_q;
  logic [cps_pkg::ADDR_W-1:0]       walk_addr_q;
  logic [cps_pkg::LBL_W-1:0]        col_q;

  logic                             s1_v_q;
  logic [cps_pkg::ADDR_W-1:0]       s1_addr_q;
  logic                             fwd_v_q;
  logic [cps_pkg::ADDR_W-1:0]       fwd_addr_q;
  logic [cps_pkg::COUNT_BITS-1:0]   fwd_data_q;

  logic                             wk_v_q;
  logic [cps_pkg::ADDR_W-1:0]       wk_addr_q;
  logic                             wk_row_end_q;
  logic [cps_pkg::COUNT_BITS-1:0]   row_max_q;
  logic [cps_pkg::SUM_W-1:0]        sum_q;
  logic [cps_pkg::COUNT_BITS-1:0]   items_q;

  logic                             out_valid_q;
  logic [cps_pkg::OUT_W-1:0]        overlap_sum_q;
  logic [cps_pkg::OUT_W-1:0]        item_total_q;
  logic [cps_pkg::PUR_W-1:0]        purity_q;

  logic                             in_accept;
  logic [cps_pkg::ADDR_W-1:0]       in_addr;
  logic [cps_pkg::ADDR_W-1:0]       rd_addr;
  logic [cps_pkg::COUNT_BITS-1:0]   rd_data;
  logic [cps_pkg::COUNT_BITS-1:0]   old_cnt;
  logic [cps_pkg::COUNT_BITS-1:0]   new_cnt;
  logic [cps_pkg::COUNT_BITS-1:0]   row_max;
  logic                             we;
  logic [cps_pkg::ADDR_W-1:0]       waddr;
  logic [cps_pkg::COUNT_BITS-1:0]   wdata;
  logic                             div_start;
  logic                             out_free;
  cps_pkg::div_stat_t               div_stat;

  always_comb begin
    in_accept = in_valid_i && (state_q == ST_ACCUM);
    in_addr   = cps_pkg::ADDR_W'(clamp_label(found_label_i)) *
                cps_pkg::ADDR_W'(cps_pkg::LABELS) +
                cps_pkg::ADDR_W'(clamp_label(reference_label_i));
    rd_addr   = (state_q == ST_WALK) ? walk_addr_q : in_addr;

    // The previous item may have written this entry at the edge of our read.
    old_cnt = (fwd_v_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data;
    new_cnt = cps_pkg::sat_inc(old_cnt);
    row_max = (rd_data > row_max_q) ? rd_data : row_max_q;

    div_start = (state_q == ST_DIV_START);
    out_free  = !out_valid_q || out_ready_i;

    priority if (s1_v_q) begin
      we    = 1'b1;
      waddr = s1_addr_q;
      wdata = new_cnt;
    end else if (wk_v_q) begin
      we    = 1'b1;
      waddr = wk_addr_q;
      wdata = '0;
    end else if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = walk_addr_q;
      wdata = '0;
    end else begin
      we    = 1'b0;
      waddr = walk_addr_q;
      wdata = '0;
    end
  end

  cps_ram #(
    .WIDTH(cps_pkg::COUNT_BITS),
    .DEPTH(cps_pkg::DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  cps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum_q),
    .total_i(items_q),
    .stat_o (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      walk_addr_q  <= '0;
      col_q        <= '0;
      s1_v_q       <= 1'b0;
      fwd_v_q      <= 1'b0;
      wk_v_q       <= 1'b0;
      wk_row_end_q <= 1'b0;
      row_max_q    <= '0;
      sum_q        <= '0;
      items_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_v_q     <= in_accept;
      s1_addr_q  <= in_addr;
      fwd_v_q    <= s1_v_q;
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_cnt;

      wk_v_q       <= (state_q == ST_WALK);
      wk_addr_q    <= walk_addr_q;
      wk_row_end_q <= (col_q == cps_pkg::LBL_W'(cps_pkg::LABELS - 1));

      if (wk_v_q) begin
        if (wk_row_end_q) begin
          sum_q     <= sum_q + cps_pkg::SUM_W'(row_max);
          row_max_q <= '0;
        end else begin
          row_max_q <= row_max;
        end
      end

      if (in_accept) begin
        items_q <= cps_pkg::sat_inc(items_q);
      end

      // A new result loaded in the same cycle keeps the register full.
      if (out_valid_q && out_ready_i && !(state_q == ST_DIV_WAIT && div_stat.done)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (walk_addr_q == cps_pkg::ADDR_W'(cps_pkg::DEPTH - 1)) begin
            walk_addr_q <= '0;
            state_q     <= ST_ACCUM;
          end else begin
            walk_addr_q <= walk_addr_q + cps_pkg::ADDR_W'(1);
          end
        end
        ST_ACCUM: begin
          if (in_accept && last_item_i) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (col_q == cps_pkg::LBL_W'(cps_pkg::LABELS - 1)) begin
            col_q <= '0;
          end else begin
            col_q <= col_q + cps_pkg::LBL_W'(1);
          end
          if (walk_addr_q == cps_pkg::ADDR_W'(cps_pkg::DEPTH - 1)) begin
            walk_addr_q <= '0;
            state_q     <= ST_TAIL;
          end else begin
            walk_addr_q <= walk_addr_q + cps_pkg::ADDR_W'(1);
          end
        end
        ST_TAIL: begin
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done && out_free) begin
            out_valid_q   <= 1'b1;
            overlap_sum_q <= sat_out(sum_q);
            item_total_q  <= sat_out(cps_pkg::SUM_W'(items_q));
            purity_q      <= div_stat.quot;
            sum_q         <= '0;
            items_q       <= '0;
            state_q       <= ST_ACCUM;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_ACCUM);
  assign out_valid_o       = out_valid_q;
  assign overlap_sum_o     = overlap_sum_q;
  assign item_total_o      = item_total_q;
  assign purity_fraction_o = purity_q;

  // The item update and the walk never share the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_v_q && wk_v_q))
    else $error("item update and table walk overlap");

  // No item is taken while the table is being cleared or walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!wk_v_q && (state_q == ST_ACCUM)))
    else $error("item accepted during clear or walk");

  // The last item is always counted, so a result never has a zero total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (item_total_o != '0))
    else $error("result with zero item total");

  // The purity never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!purity_fraction_o[cps_pkg::FRAC_BITS] ||
                     (purity_fraction_o[cps_pkg::FRAC_BITS-1:0] == '0)))
    else $error("purity above one");

endmodule

// ===== sim/tb_cluster_purity_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_purity_score: self-checking bench for the purity scorer
// A short directed table covers single-item sets, empty found clusters, ties,
// and sets of full purity. Random labelled data sets follow. Each result is
// compared with a fixed expected score or with a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb_cluster_purity_score;
  import cps_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_FROM   = 1200;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 400;
  localparam int PUR_ONE      = 65536;

  typedef struct packed {
    logic [OUT_W-1:0] sum;
    logic [OUT_W-1:0] total;
    logic [PUR_W-1:0] purity;
  } score_t;

  typedef struct packed {
    logic [LABEL_IN_W-1:0] rl;
    logic [LABEL_IN_W-1:0] fl;
    logic                  is_last;
    logic [31:0]           reps;
    logic                  typed;
    score_t                want;
  } dir_row_t;

  localparam int DIR_N = 16;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [LABEL_IN_W-1:0] reference_label_i;
  logic [LABEL_IN_W-1:0] found_label_i;
  logic                  last_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [OUT_W-1:0]      overlap_sum_o;
  logic [OUT_W-1:0]      item_total_o;
  logic [PUR_W-1:0]      purity_fraction_o;

  cluster_purity_score dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .reference_label_i (reference_label_i),
    .found_label_i     (found_label_i),
    .last_item_i       (last_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .overlap_sum_o     (overlap_sum_o),
    .item_total_o      (item_total_o),
    .purity_fraction_o (purity_fraction_o)
  );

  // Behavioral contingency table: row by found label, column by reference label.
  logic [COUNT_BITS-1:0] overlap_tally [LABELS][LABELS];
  logic [COUNT_BITS-1:0] tally_items;

  score_t   score_q [$];
  score_t   got_score;
  score_t   exp_score;
  dir_row_t dir_rows [DIR_N];

  bit idle_on;
  int errors;
  int items_sent;
  int sets_sent;
  int scores_checked;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_tally();
    for (int f = 0; f < LABELS; f++) begin
      for (int r = 0; r < LABELS; r++) begin
        overlap_tally[f][r] = '0;
      end
    end
    tally_items = '0;
  endtask

  // Counts one item and, on the last item of a set, scores and clears the table.
  task automatic tally_item(input logic [LABEL_IN_W-1:0] rl, input logic [LABEL_IN_W-1:0] fl,
                            input logic is_last, output bit scored, output score_t s);
    int                    ri;
    int                    fi;
    longint unsigned       acc;
    longint unsigned       frac;
    logic [COUNT_BITS-1:0] best;
    ri = (int'(rl) >= LABELS) ? LABELS - 1 : int'(rl);
    fi = (int'(fl) >= LABELS) ? LABELS - 1 : int'(fl);
    if (overlap_tally[fi][ri] != {COUNT_BITS{1'b1}}) begin
      overlap_tally[fi][ri] = overlap_tally[fi][ri] + 1'b1;
    end
    if (tally_items != {COUNT_BITS{1'b1}}) begin
      tally_items = tally_items + 1'b1;
    end
    scored = is_last;
    s      = '0;
    if (is_last) begin
      acc = 0;
      for (int f = 0; f < LABELS; f++) begin
        best = '0;
        for (int r = 0; r < LABELS; r++) begin
          if (overlap_tally[f][r] > best) best = overlap_tally[f][r];
        end
        acc += best;
      end
      frac = (acc << 16) / longint'(tally_items);
      if (frac > PUR_ONE) frac = PUR_ONE;
      s.sum    = (acc > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(acc);
      s.total  = (tally_items > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(tally_items);
      s.purity = PUR_W'(frac);
      clear_tally();
    end
  endtask

  task automatic send_item(input logic [LABEL_IN_W-1:0] rl, input logic [LABEL_IN_W-1:0] fl,
                           input logic is_last, input bit typed, input score_t want);
    bit     scored;
    score_t pred;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    reference_label_i = rl;
    found_label_i     = fl;
    last_item_i       = is_last;
    do @(posedge clk_i); while (!in_ready_o);
    tally_item(rl, fl, is_last, scored, pred);
    items_sent++;
    if (scored) begin
      score_q = {score_q, (typed ? want : pred)};
      sets_sent++;
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_score = '{overlap_sum_o, item_total_o, purity_fraction_o};
      if (score_q.size() == 0) begin
        $error("unexpected result: sum %0d total %0d purity %0d",
               overlap_sum_o, item_total_o, purity_fraction_o);
        errors++;
      end else begin
        exp_score = score_q.pop_front();
        scores_checked++;
        if (got_score.sum !== exp_score.sum) begin
          $error("overlap_sum: expected %0d, actual %0d", exp_score.sum, got_score.sum);
          errors++;
        end
        if (got_score.total !== exp_score.total) begin
          $error("item_total: expected %0d, actual %0d", exp_score.total, got_score.total);
          errors++;
        end
        if (got_score.purity !== exp_score.purity) begin
          $error("purity_fraction: expected %0d, actual %0d",
                 exp_score.purity, got_score.purity);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_cluster_purity_score: errors");
      $finish;
    end
  end

  // Result side: random bursts of back-pressure while idling is enabled.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin
    logic [LABEL_IN_W-1:0] rl;
    logic [LABEL_IN_W-1:0] fl;
    logic [LABEL_IN_W-1:0] cluster_map [LABELS];
    logic [LABEL_IN_W-1:0] base;
    int                    set_len;
    int                    nref;
    int                    noise;
    int                    random_sent;

    in_valid_i        = 1'b0;
    reference_label_i = '0;
    found_label_i     = '0;
    last_item_i       = 1'b0;
    rst_ni            = 1'b0;
    idle_on           = 1'b1;
    errors            = 0;
    items_sent        = 0;
    sets_sent         = 0;
    scores_checked    = 0;
    stall_cycles      = 0;
    random_sent       = 0;
    clear_tally();

    // Rows within a data set run until a row with the last flag. A row repeats
    // its item reps times; only the final copy carries the flag.
    dir_rows = '{
      '{4'd0,  4'd0,  1'b1, 32'd1,     1'b1, '{16'd1,     16'd1,     17'd65536}},
      '{4'd15, 4'd15, 1'b1, 32'd1,     1'b1, '{16'd1,     16'd1,     17'd65536}},
      // Tie inside one found cluster.
      '{4'd3,  4'd7,  1'b0, 32'd1,     1'b0, '0},
      '{4'd4,  4'd7,  1'b1, 32'd1,     1'b1, '{16'd1,     16'd2,     17'd32768}},
      // One found cluster, three reference clusters.
      '{4'd0,  4'd0,  1'b0, 32'd1,     1'b0, '0},
      '{4'd1,  4'd0,  1'b0, 32'd1,     1'b0, '0},
      '{4'd2,  4'd0,  1'b1, 32'd1,     1'b1, '{16'd1,     16'd3,     17'd21845}},
      // Every item in a found cluster of its own.
      '{4'd5,  4'd0,  1'b0, 32'd1,     1'b0, '0},
      '{4'd5,  4'd1,  1'b0, 32'd1,     1'b0, '0},
      '{4'd5,  4'd2,  1'b1, 32'd1,     1'b1, '{16'd3,     16'd3,     17'd65536}},
      // Mostly empty found clusters.
      '{4'd9,  4'd12, 1'b0, 32'd3,     1'b0, '0},
      '{4'd2,  4'd12, 1'b0, 32'd2,     1'b0, '0},
      '{4'd9,  4'd4,  1'b0, 32'd1,     1'b0, '0},
      '{4'd15, 4'd0,  1'b1, 32'd1,     1'b0, '0},
      // The table must come back cleared after a set.
      '{4'd10, 4'd5,  1'b0, 32'd1,     1'b0, '0},
      '{4'd5,  4'd10, 1'b1, 32'd1,     1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < int'(dir_rows[i].reps); k++) begin
        send_item(dir_rows[i].rl, dir_rows[i].fl,
                  dir_rows[i].is_last && (k == int'(dir_rows[i].reps) - 1),
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random data sets: each reference cluster mostly maps to one found cluster,
    // with a per-set share of stray items.
    while (random_sent < RANDOM_ITEMS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 250) : $urandom_range(1, 30);
      nref    = $urandom_range(1, LABELS);
      base    = LABEL_IN_W'($urandom_range(0, LABELS - 1));
      noise   = $urandom_range(0, 60);
      foreach (cluster_map[r]) cluster_map[r] = LABEL_IN_W'($urandom_range(0, LABELS - 1));
      for (int k = 0; k < set_len; k++) begin
        if (random_sent >= QUIET_FROM) idle_on = 1'b0;
        rl = base + LABEL_IN_W'($urandom_range(0, nref - 1));
        fl = ($urandom_range(0, 99) < noise) ? LABEL_IN_W'($urandom_range(0, LABELS - 1))
                                             : cluster_map[rl];
        send_item(rl, fl, k == set_len - 1, 1'b0, '0);
        random_sent++;
      end
    end

    @(negedge clk_i);
    in_valid_i  = 1'b0;
    last_item_i = 1'b0;

    while (score_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d items in %0d data sets with idle bursts on both sides;",
             items_sent, sets_sent);
    $display("%0d purity results compared against the behavioral table.", scores_checked);
    if (errors == 0) begin
      $display("tb_cluster_purity_score: clean");
    end else begin
      $display("tb_cluster_purity_score: errors");
    end
    $finish;
  end

endmodule

// ===== cluster_purity_score.f =====
sv/cps_pkg.sv
sv/cps_ram.sv
sv/cps_div.sv
sv/cluster_purity_score.sv
sim/tb_cluster_purity_score.sv
